@@ src/card_job_word_machine_defines.svh @@
// ----------------------------------------------------------------------------
// Card job word machine assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef CARD_JOB_WORD_MACHINE_DEFINES_SVH
`define CARD_JOB_WORD_MACHINE_DEFINES_SVH

// Same-cycle implication.
`define CJWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cjwm assertion failed");

// Next-cycle implication.
`define CJWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cjwm assertion failed");

`endif

@@ src/cjwm_pkg.sv @@
// ----------------------------------------------------------------------------
// Card job word machine package
// Default sizes, character codes, command, status and run mode encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package cjwm_pkg;

	localparam int MEM_WORDS_DEF   = 100;
	localparam int BLOCK_WORDS_DEF = 10;

	localparam logic [31:0] SPACES4  = 32'h2020_2020;
	localparam logic [31:0] END_WORD = 32'h2445_4E44;

	localparam logic [7:0] CH_G    = 8'h47;
	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_H    = 8'h48;
	localparam logic [7:0] CH_L    = 8'h4C;
	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_B    = 8'h42;
	localparam logic [7:0] CH_T    = 8'h54;
	localparam logic [7:0] CH_R    = 8'h52;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef enum logic [2:0] {
		CMD_LOAD  = 3'd0,
		CMD_INIT  = 3'd1,
		CMD_START = 3'd2,
		CMD_STEP  = 3'd3,
		CMD_CARD  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_OUT      = 3'd1,
		ST_HALT     = 3'd2,
		ST_CARD     = 3'd3,
		ST_BADADDR  = 3'd4,
		ST_NOTREADY = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_RUN  = 2'd1,
		MODE_CARD = 2'd2,
		MODE_HALT = 2'd3
	} mode_t;

	function automatic logic is_digit(input logic [7:0] ch);
		return (ch >= CH_ZERO) && (ch <= CH_NINE);
	endfunction

endpackage

`default_nettype wire

@@ src/card_job_word_machine.sv @@
// ----------------------------------------------------------------------------
// Card job word machine
// Word-addressed teaching machine: program load, init, start, single-step
// execution of LR/SR/CR/BT/GD/PD/H and card word supply, around one
// single-port word memory under a small sequencer.
// ----------------------------------------------------------------------------
//
// Channel   Handshake             Payload
// -------   -------------------   ------------------------------
// command   start, busy           command, address, word
// result    done (one cycle)      status, out_word, last
//
// An item is taken when start is high and busy is low.
// load_word, init, start, card_word: handled in S_CMD; result registered on return to idle.
// step: S_CMD only when refused, else S_CMD (fetch) and S_DECODE, plus S_OPER
// for LR and CR (operand read) or S_PD for PD, one word per cycle from memory.
// Reset and init clear per-word valid bits at once; no clearing pass.
// Results cannot be stalled; each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "card_job_word_machine_defines.svh"

module card_job_word_machine #(
	parameter int MEM_WORDS   = cjwm_pkg::MEM_WORDS_DEF,
	parameter int BLOCK_WORDS = cjwm_pkg::BLOCK_WORDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  command,
	input  wire logic [6:0]  address,
	input  wire logic [31:0] word,
	output logic             done,
	output logic [2:0]       status,
	output logic [31:0]      out_word,
	output logic             last
);

	localparam int          AW      = $clog2(MEM_WORDS);
	localparam logic [6:0]  MEM_LIM = 7'(MEM_WORDS);
	localparam logic [7:0]  BLK_LIM = 8'(BLOCK_WORDS);
	localparam logic [3:0]  BLK_CNT = 4'(BLOCK_WORDS);
	localparam logic [3:0]  BLK_END = 4'(BLOCK_WORDS - 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_CMD    = 5'b00010,
		S_DECODE = 5'b00100,
		S_OPER   = 5'b01000,
		S_PD     = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	cjwm_pkg::mode_t   mode_q, mode_d;
	logic [6:0]        ic_q, ic_d;
	logic [6:0]        cp_q, cp_d;
	logic [3:0]        cc_q, cc_d;
	logic              flag_q, flag_d;
	logic [31:0]       gr_q, gr_d;
	logic [6:0]        ptr_q, ptr_d;
	logic [3:0]        cnt_q, cnt_d;
	logic              is_load_q, is_load_d;

	logic [2:0]        cmd_q;
	logic [6:0]        addr_q;
	logic [31:0]       word_q;

	logic              done_q, done_d;
	cjwm_pkg::status_t status_q, status_d;
	logic [31:0]       out_word_q, out_word_d;
	logic              last_q, last_d;

	logic [31:0]          mem_q [MEM_WORDS];
	logic [MEM_WORDS-1:0] valid_q;
	logic [31:0]          rdata_q;
	logic                 rvalid_q;
	logic [31:0]          rd_word;

	logic        rd_en;
	logic [6:0]  rd_addr;
	logic        wr_en;
	logic [6:0]  wr_addr;
	logic [31:0] wr_data;
	logic        clr_valid;

	logic [7:0]  c0, c1, c2, c3;
	logic [6:0]  loc_blk, loc_full;
	logic        accept;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign done     = done_q;
	assign status   = status_q;
	assign out_word = out_word_q;
	assign last     = last_q;

	assign rd_word  = rvalid_q ? rdata_q : cjwm_pkg::SPACES4;
	assign c0       = rd_word[31:24];
	assign c1       = rd_word[23:16];
	assign c2       = rd_word[15:8];
	assign c3       = rd_word[7:0];
	assign loc_blk  = {c2[3:0], 3'b000} + {2'b00, c2[3:0], 1'b0};
	assign loc_full = loc_blk + {3'b000, c3[3:0]};

	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		ic_d       = ic_q;
		cp_d       = cp_q;
		cc_d       = cc_q;
		flag_d     = flag_q;
		gr_d       = gr_q;
		ptr_d      = ptr_q;
		cnt_d      = cnt_q;
		is_load_d  = is_load_q;
		done_d     = 1'b0;
		status_d   = cjwm_pkg::ST_OK;
		out_word_d = '0;
		last_d     = 1'b1;
		rd_en      = 1'b0;
		rd_addr    = ic_q;
		wr_en      = 1'b0;
		wr_addr    = addr_q;
		wr_data    = word_q;
		clr_valid  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_CMD;
				end
			end
			S_CMD: begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				case (cmd_q)
					cjwm_pkg::CMD_LOAD: begin
						if (addr_q < MEM_LIM) begin
							wr_en = 1'b1;
						end else begin
							status_d = cjwm_pkg::ST_BADADDR;
						end
					end
					cjwm_pkg::CMD_INIT: begin
						clr_valid = 1'b1;
						flag_d    = 1'b0;
						ic_d      = '0;
						cp_d      = '0;
						cc_d      = '0;
						mode_d    = cjwm_pkg::MODE_IDLE;
					end
					cjwm_pkg::CMD_START: begin
						ic_d   = '0;
						cp_d   = '0;
						cc_d   = '0;
						mode_d = cjwm_pkg::MODE_RUN;
					end
					cjwm_pkg::CMD_STEP: begin
						if (mode_q != cjwm_pkg::MODE_RUN) begin
							status_d = cjwm_pkg::ST_NOTREADY;
						end else if (ic_q >= MEM_LIM) begin
							mode_d   = cjwm_pkg::MODE_IDLE;
							status_d = cjwm_pkg::ST_BADADDR;
						end else begin
							rd_en   = 1'b1;
							rd_addr = ic_q;
							ic_d    = ic_q + 7'd1;
							done_d  = 1'b0;
							state_d = S_DECODE;
						end
					end
					cjwm_pkg::CMD_CARD: begin
						if (mode_q != cjwm_pkg::MODE_CARD) begin
							status_d = cjwm_pkg::ST_NOTREADY;
						end else if (cp_q >= MEM_LIM) begin
							mode_d = cjwm_pkg::MODE_RUN;
						end else begin
							wr_en   = 1'b1;
							wr_addr = cp_q;
							if (word_q == cjwm_pkg::END_WORD) begin
								mode_d = cjwm_pkg::MODE_RUN;
							end else begin
								cp_d = cp_q + 7'd1;
								cc_d = cc_q + 4'd1;
								if ((cc_q + 4'd1) >= BLK_CNT) begin
									mode_d = cjwm_pkg::MODE_RUN;
								end else begin
									status_d = cjwm_pkg::ST_CARD;
								end
							end
						end
					end
					default: begin
						status_d = cjwm_pkg::ST_NOTREADY;
					end
				endcase
			end
			S_DECODE: begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				if (c0 == cjwm_pkg::CH_H) begin
					mode_d   = cjwm_pkg::MODE_HALT;
					status_d = cjwm_pkg::ST_HALT;
				end else if ((c0 == cjwm_pkg::CH_G || c0 == cjwm_pkg::CH_P) &&
						c1 == cjwm_pkg::CH_D) begin
					if (!cjwm_pkg::is_digit(c2) ||
							({1'b0, loc_blk} + BLK_LIM) > {1'b0, MEM_LIM}) begin
						mode_d   = cjwm_pkg::MODE_IDLE;
						status_d = cjwm_pkg::ST_BADADDR;
					end else if (c0 == cjwm_pkg::CH_G) begin
						cp_d     = loc_blk;
						cc_d     = '0;
						mode_d   = cjwm_pkg::MODE_CARD;
						status_d = cjwm_pkg::ST_CARD;
					end else begin
						rd_en   = 1'b1;
						rd_addr = loc_blk;
						ptr_d   = loc_blk + 7'd1;
						cnt_d   = '0;
						done_d  = 1'b0;
						state_d = S_PD;
					end
				end else if ((c0 == cjwm_pkg::CH_L || c0 == cjwm_pkg::CH_S ||
						c0 == cjwm_pkg::CH_C) && c1 == cjwm_pkg::CH_R ||
						c0 == cjwm_pkg::CH_B && c1 == cjwm_pkg::CH_T) begin
					if (!cjwm_pkg::is_digit(c2) || !cjwm_pkg::is_digit(c3) ||
							loc_full >= MEM_LIM) begin
						mode_d   = cjwm_pkg::MODE_IDLE;
						status_d = cjwm_pkg::ST_BADADDR;
					end else if (c0 == cjwm_pkg::CH_L || c0 == cjwm_pkg::CH_C) begin
						rd_en     = 1'b1;
						rd_addr   = loc_full;
						is_load_d = (c0 == cjwm_pkg::CH_L);
						done_d    = 1'b0;
						state_d   = S_OPER;
					end else if (c0 == cjwm_pkg::CH_S) begin
						wr_en   = 1'b1;
						wr_addr = loc_full;
						wr_data = gr_q;
					end else if (flag_q) begin
						ic_d   = loc_full;
						flag_d = 1'b0;
					end
				end
			end
			S_OPER: begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				if (is_load_q) begin
					gr_d = rd_word;
				end else begin
					flag_d = (rd_word == gr_q);
				end
			end
			S_PD: begin
				done_d     = 1'b1;
				status_d   = cjwm_pkg::ST_OUT;
				out_word_d = rd_word;
				last_d     = (cnt_q == BLK_END);
				if (cnt_q == BLK_END) begin
					state_d = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = ptr_q;
					ptr_d   = ptr_q + 7'd1;
					cnt_d   = cnt_q + 4'd1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mode_q    <= cjwm_pkg::MODE_IDLE;
			ic_q      <= '0;
			cp_q      <= '0;
			cc_q      <= '0;
			flag_q    <= 1'b0;
			gr_q      <= cjwm_pkg::SPACES4;
			ptr_q     <= '0;
			cnt_q     <= '0;
			is_load_q <= 1'b0;
			done_q    <= 1'b0;
			valid_q   <= '0;
		end else begin
			state_q   <= state_d;
			mode_q    <= mode_d;
			ic_q      <= ic_d;
			cp_q      <= cp_d;
			cc_q      <= cc_d;
			flag_q    <= flag_d;
			gr_q      <= gr_d;
			ptr_q     <= ptr_d;
			cnt_q     <= cnt_d;
			is_load_q <= is_load_d;
			done_q    <= done_d;
			if (clr_valid) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr[AW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command;
			addr_q <= address;
			word_q <= word;
		end
		status_q   <= status_d;
		out_word_q <= out_word_d;
		last_q     <= last_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rdata_q  <= mem_q[rd_addr[AW-1:0]];
			rvalid_q <= valid_q[rd_addr[AW-1:0]];
		end
	end

	`CJWM_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy)
	`CJWM_ASSERT_NOW(a_mid_stream_busy, clk, arst_n, done && !last, busy)
	`CJWM_ASSERT_NEXT(a_last_gap, clk, arst_n, done && last, !done)
	`CJWM_ASSERT_NOW(a_out_running, clk, arst_n,
		done && status == cjwm_pkg::ST_OUT, mode_q == cjwm_pkg::MODE_RUN)
	`CJWM_ASSERT_NOW(a_card_count, clk, arst_n,
		mode_q == cjwm_pkg::MODE_CARD, cc_q < BLK_CNT)

endmodule

`default_nettype wire
